FILE: rtl/sot_pkg.sv
package sot_pkg;

   // table geometry
   localparam int SLOTS    = 16;
   localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SLOT_W   = 4;
   localparam int CMP_W    = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   // field widths
   localparam int COORD_W  = 24;
   localparam int RAD_W    = 24;
   localparam int SRAD_W   = 23;
   localparam int ENTRY_W  = 3 * COORD_W + SRAD_W;

   // cycles from the last table read to the final overlap flag
   localparam int DRAIN_CYCLES = 4;
   localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);
   localparam logic [DRAIN_W-1:0] DRAIN_LAST = DRAIN_W'(DRAIN_CYCLES - 1);

   typedef enum logic [1:0] {
      ST_DONE       = 2'd0,
      ST_OVERLAP    = 2'd1,
      ST_NEG_RADIUS = 2'd2,
      ST_EMPTY      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CS_IDLE,
      CS_DECIDE,
      CS_SCAN,
      CS_DRAIN,
      CS_RESP
   } ctl_state_type;

   typedef struct packed {
      logic             load;
      logic             scan_en;
      logic [IDX_W-1:0] scan_idx;
      logic             respond;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_remove;
      logic neg_radius;
   } dp_status_type;

endpackage

FILE: rtl/sot_ctrl.sv
module sot_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  sot_pkg::dp_status_type dp_status,
   output sot_pkg::ctl_cmd_type  cmd,
   output logic                  busy
);
   import sot_pkg::*;

   ctl_state_type      state_ff, state_in;
   logic [IDX_W-1:0]   scan_cnt_ff, scan_cnt_in;
   logic [DRAIN_W-1:0] drain_cnt_ff, drain_cnt_in;

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CS_IDLE;
         scan_cnt_ff  <= '0;
         drain_cnt_ff <= '0;
      end else begin
         state_ff     <= state_in;
         scan_cnt_ff  <= scan_cnt_in;
         drain_cnt_ff <= drain_cnt_in;
      end
   end

   // next state
   always_comb begin
      state_in     = state_ff;
      scan_cnt_in  = scan_cnt_ff;
      drain_cnt_in = drain_cnt_ff;
      unique case (state_ff)
         CS_IDLE: begin
            if (start) state_in = CS_DECIDE;
         end
         CS_DECIDE: begin
            scan_cnt_in  = '0;
            drain_cnt_in = '0;
            if (dp_status.is_remove || dp_status.neg_radius) state_in = CS_RESP;
            else state_in = CS_SCAN;
         end
         CS_SCAN: begin
            scan_cnt_in = scan_cnt_ff + 1'b1;
            if (scan_cnt_ff == LAST_IDX) state_in = CS_DRAIN;
         end
         CS_DRAIN: begin
            drain_cnt_in = drain_cnt_ff + 1'b1;
            if (drain_cnt_ff == DRAIN_LAST) state_in = CS_RESP;
         end
         CS_RESP: begin
            state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd.load     = 1'b0;
      cmd.scan_en  = 1'b0;
      cmd.scan_idx = scan_cnt_ff;
      cmd.respond  = 1'b0;
      busy         = 1'b1;
      unique case (state_ff)
         CS_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         CS_DECIDE: ;
         CS_SCAN:   cmd.scan_en = 1'b1;
         CS_DRAIN:  ;
         CS_RESP:   cmd.respond = 1'b1;
         default:   ;
      endcase
   end

`ifndef SYNTHESIS
   a_resp_then_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_RESP) |=> (state_ff == CS_IDLE))
      else $error("response state not followed by idle");
   a_scan_from_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_DECIDE) |=> (scan_cnt_ff == '0))
      else $error("scan does not start at entry zero");
   a_drain_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == CS_SCAN && scan_cnt_ff == LAST_IDX) |=> (state_ff == CS_DRAIN))
      else $error("scan did not end after last entry");
`endif

endmodule

FILE: rtl/sot_datapath.sv
module sot_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  sot_pkg::ctl_cmd_type   cmd,
   input  logic                   req_action,
   input  logic [3:0]             req_slot,
   input  logic signed [23:0]     req_center_x,
   input  logic signed [23:0]     req_center_y,
   input  logic signed [23:0]     req_center_z,
   input  logic signed [23:0]     req_radius,
   output sot_pkg::dp_status_type dp_status,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_status
);
   import sot_pkg::*;

   // latched item
   logic                      action_ff;
   logic [SLOT_W-1:0]         slot_ff;
   logic signed [COORD_W-1:0] x_ff, y_ff, z_ff;
   logic signed [RAD_W-1:0]   r_ff;

   // table
   logic [ENTRY_W-1:0] mem [SLOTS];
   logic [SLOTS-1:0]   valid_ff;
   logic [ENTRY_W-1:0] rd_q_ff;

   // compare pipeline
   logic               p1_vld_ff, p2_vld_ff, p3_vld_ff, p4_vld_ff;
   logic [24:0]        ax_ff, ay_ff, az_ff;
   logic [23:0]        rsum_ff;
   logic [49:0]        sqx_ff, sqy_ff, sqz_ff;
   logic [47:0]        rs2_p3_ff, rs2_p4_ff;
   logic [51:0]        d2_ff;
   logic               overlap_ff;

   logic               rsp_valid_ff;
   status_type         rsp_status_ff, status_in;

   logic signed [COORD_W-1:0] e_x, e_y, e_z;
   logic [SRAD_W-1:0]         e_r;
   logic signed [24:0]        dx, dy, dz;
   logic                      in_table, own_hit, slot_valid, do_write;
   logic [IDX_W-1:0]          slot_idx;

   assign slot_idx   = IDX_W'(slot_ff);
   assign in_table   = 32'(slot_ff) < SLOTS;
   assign slot_valid = in_table && valid_ff[slot_idx];
   assign own_hit    = CMP_W'(cmd.scan_idx) == CMP_W'(slot_ff);

   // capture item on accept
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         slot_ff   <= req_slot;
         x_ff      <= req_center_x;
         y_ff      <= req_center_y;
         z_ff      <= req_center_z;
         r_ff      <= req_radius;
      end
   end

   assign dp_status.is_remove  = action_ff;
   assign dp_status.neg_radius = r_ff[RAD_W-1];

   // response status
   always_comb begin
      status_in = ST_DONE;
      do_write  = 1'b0;
      priority if (action_ff) begin
         if (slot_valid) status_in = ST_DONE;
         else status_in = ST_EMPTY;
      end else if (r_ff[RAD_W-1]) begin
         status_in = ST_NEG_RADIUS;
      end else if (overlap_ff) begin
         status_in = ST_OVERLAP;
      end else begin
         status_in = ST_DONE;
         do_write  = in_table;
      end
   end

   // table write and scan read
   always_ff @(posedge clock) begin
      if (cmd.respond && do_write) begin
         mem[slot_idx] <= {x_ff, y_ff, z_ff, r_ff[SRAD_W-1:0]};
      end
      rd_q_ff <= mem[cmd.scan_idx];
   end

   // valid bits: set on place, clear on remove
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.respond) begin
         if (do_write) valid_ff[slot_idx] <= 1'b1;
         else if (action_ff && slot_valid) valid_ff[slot_idx] <= 1'b0;
      end
   end

   assign e_x = rd_q_ff[ENTRY_W-1 -: COORD_W];
   assign e_y = rd_q_ff[ENTRY_W-1-COORD_W -: COORD_W];
   assign e_z = rd_q_ff[ENTRY_W-1-2*COORD_W -: COORD_W];
   assign e_r = rd_q_ff[SRAD_W-1:0];

   assign dx = 25'(e_x) - 25'(x_ff);
   assign dy = 25'(e_y) - 25'(y_ff);
   assign dz = 25'(e_z) - 25'(z_ff);

   // pipeline tags
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
      end else begin
         p1_vld_ff <= cmd.scan_en && valid_ff[cmd.scan_idx] && !own_hit;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
      end
   end

   // distances, squares, sum
   always_ff @(posedge clock) begin
      ax_ff     <= dx[24] ? 25'(-dx) : 25'(dx);
      ay_ff     <= dy[24] ? 25'(-dy) : 25'(dy);
      az_ff     <= dz[24] ? 25'(-dz) : 25'(dz);
      rsum_ff   <= 24'(e_r) + 24'(r_ff[SRAD_W-1:0]);
      sqx_ff    <= 50'(ax_ff) * 50'(ax_ff);
      sqy_ff    <= 50'(ay_ff) * 50'(ay_ff);
      sqz_ff    <= 50'(az_ff) * 50'(az_ff);
      rs2_p3_ff <= 48'(rsum_ff) * 48'(rsum_ff);
      d2_ff     <= 52'(sqx_ff) + 52'(sqy_ff) + 52'(sqz_ff);
      rs2_p4_ff <= rs2_p3_ff;
   end

   // accumulate overlap over the scan
   always_ff @(posedge clock) begin
      if (reset) begin
         overlap_ff <= 1'b0;
      end else if (cmd.load) begin
         overlap_ff <= 1'b0;
      end else if (p4_vld_ff && (d2_ff <= 52'(rs2_p4_ff))) begin
         overlap_ff <= 1'b1;
      end
   end

   // one-cycle result strobe
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= cmd.respond;
      if (cmd.respond) rsp_status_ff <= status_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

`ifndef SYNTHESIS
   a_no_scan_at_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |-> !(p1_vld_ff || p2_vld_ff || p3_vld_ff || p4_vld_ff))
      else $error("response issued while compare pipeline busy");
   a_strobe_follows_resp: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> rsp_valid_ff)
      else $error("missing result strobe");
   a_overlap_clear_on_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> !overlap_ff)
      else $error("overlap flag not cleared for new item");
`endif

endmodule

FILE: rtl/sphere_overlap_table_unit.sv
// Place with radius >= 0: result strobe after the full table scan and pipeline drain;
// the table is read one entry per cycle through a five-stage compare pipeline.
// Remove or negative-radius place: no scan; strobe after decide and response states.
// A new item may be accepted in the cycle of the result strobe; results cannot stall.
// Synchronous active-high reset clears all valid bits and returns to idle at once.
module sphere_overlap_table_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_action,
   input  logic [3:0]         req_slot,
   input  logic signed [23:0] req_center_x,
   input  logic signed [23:0] req_center_y,
   input  logic signed [23:0] req_center_z,
   input  logic signed [23:0] req_radius,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status
);
   import sot_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type dp_status;

   sot_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .dp_status (dp_status),
      .cmd       (cmd),
      .busy      (busy)
   );

   sot_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_action   (req_action),
      .req_slot     (req_slot),
      .req_center_x (req_center_x),
      .req_center_y (req_center_y),
      .req_center_z (req_center_z),
      .req_radius   (req_radius),
      .dp_status    (dp_status),
      .rsp_valid    (rsp_valid),
      .rsp_status   (rsp_status)
   );

`ifndef SYNTHESIS
   a_accept_sets_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted item did not make unit busy");
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");
   a_strobe_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");
`endif

endmodule
